// File: src/bsc_pkg.sv
`default_nettype none

package bsc_pkg;

  // Controller state codes, also used as the datapath operation codes.
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_T0   = 5'd1;
  localparam logic [4:0] ST_T1   = 5'd2;
  localparam logic [4:0] ST_T2   = 5'd3;
  localparam logic [4:0] ST_TFIN = 5'd4;
  localparam logic [4:0] ST_P0   = 5'd5;
  localparam logic [4:0] ST_P1   = 5'd6;
  localparam logic [4:0] ST_P2   = 5'd7;
  localparam logic [4:0] ST_P3   = 5'd8;
  localparam logic [4:0] ST_P4   = 5'd9;
  localparam logic [4:0] ST_P5   = 5'd10;
  localparam logic [4:0] ST_P6   = 5'd11;
  localparam logic [4:0] ST_P7   = 5'd12;
  localparam logic [4:0] ST_P8   = 5'd13;
  localparam logic [4:0] ST_P9   = 5'd14;
  localparam logic [4:0] ST_P10  = 5'd15;
  localparam logic [4:0] ST_DIV1 = 5'd16;
  localparam logic [4:0] ST_P11  = 5'd17;
  localparam logic [4:0] ST_P12  = 5'd18;
  localparam logic [4:0] ST_DIV2 = 5'd19;
  localparam logic [4:0] ST_P13  = 5'd20;
  localparam logic [4:0] ST_P14  = 5'd21;
  localparam logic [4:0] ST_P15  = 5'd22;
  localparam logic [4:0] ST_P16  = 5'd23;
  localparam logic [4:0] ST_P17  = 5'd24;
  localparam logic [4:0] ST_P18  = 5'd25;
  localparam logic [4:0] ST_PFIN = 5'd26;
  localparam logic [4:0] ST_ZFIN = 5'd27;

  // Input opcodes.
  localparam logic OPC_TEMP  = 1'b0;
  localparam logic OPC_PRESS = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TEMP = 2'd0;
  localparam logic [1:0] CFG_PLOW = 2'd1;
  localparam logic [1:0] CFG_PMID = 2'd2;
  localparam logic [1:0] CFG_PTOP = 2'd3;

  localparam int CFG_DATA_W = 64;

  localparam logic signed [23:0] T_OFFSET  = 24'sd128000;
  localparam logic [63:0]        DIV_LIMIT = 64'd351843720;
  localparam logic [41:0]        P_LIMIT   = 42'h100_0000_0000;
  localparam logic signed [63:0] ACC_BIAS  = 64'sh0000_8000_0000_0000;
  localparam logic signed [63:0] OUT_MAX   = 64'sh0000_0000_FFFF_FFFF;
  localparam logic signed [16:0] SCALE_5P5 = 17'sd3125;

  localparam logic [6:0] DIV_STEPS_FULL = 7'd64;
  localparam logic [6:0] DIV_STEPS_FRAC = 7'd12;

  typedef struct packed {
    logic [4:0] op;
    logic       exec;
    logic       load;
  } dp_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: src/bsc_divider.sv
`default_nettype none

module bsc_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [38:0] rem_init,
  input  wire logic [63:0] dividend,
  input  wire logic [38:0] divisor,
  input  wire logic [6:0]  steps,
  output logic             busy,
  output logic [63:0]      quotient,
  output logic [38:0]      remainder
);

  logic [38:0] rem;
  logic [63:0] bits;
  logic [38:0] dsr;
  logic [6:0]  count;
  logic [39:0] shifted;
  logic        ge;

  // Restoring division, one quotient bit a cycle. The dividend bits shift out
  // at the top while the quotient bits shift in at the bottom.
  assign shifted = {rem, bits[63]};
  assign ge      = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= steps;
    end else if (count != '0) begin
      count <= count - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rem_init;
      bits <= dividend;
      dsr  <= divisor;
    end else if (count != '0) begin
      if (ge) begin
        rem <= 39'(shifted - {1'b0, dsr});
      end else begin
        rem <= shifted[38:0];
      end
      bits <= {bits[62:0], ge};
    end
  end

  assign busy      = (count != '0);
  assign quotient  = bits;
  assign remainder = rem;

endmodule

`default_nettype wire

// File: src/bsc_datapath.sv
`default_nettype none

module bsc_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write_en,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [63:0]           cfg_data,
  input  wire logic [19:0]           raw_sample,
  input  wire logic                  out_stall,
  input  wire bsc_pkg::dp_cmd_t      cmd,
  output bsc_pkg::dp_stat_t          stat,
  output logic                       out_valid,
  output logic                       result_kind,
  output logic signed [23:0]         temperature_centi,
  output logic [31:0]                pressure_q24_8,
  output logic                       zero_divisor
);

  localparam logic signed [23:0] T_OFFSET_L = bsc_pkg::T_OFFSET;

  logic [47:0] temp_cal;
  logic [63:0] plow;
  logic [63:0] pmid;
  logic [15:0] ptop;

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  logic [19:0]        adc;
  logic signed [22:0] fine;
  logic signed [72:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] acc2;
  logic signed [45:0] tvv;
  logic [15:0]        tlo;
  logic signed [39:0] den;
  logic               qsign;
  logic               qbig;
  logic [28:0]        qlow;
  logic signed [41:0] preg;

  logic signed [55:0] mul_a;
  logic signed [16:0] mul_b;
  logic               prod_en;

  logic signed [17:0] e1;
  logic signed [16:0] dlt;
  logic signed [23:0] v;
  logic signed [28:0] s13;
  logic [20:0]        span;
  logic signed [63:0] num_base;
  logic signed [63:0] fine_sum;
  logic signed [22:0] fine_next;
  logic signed [26:0] t5;
  logic signed [23:0] temp_val;
  logic [63:0]        num_mag;
  logic [38:0]        den_mag;
  logic [41:0]        msum;
  logic [41:0]        mag;
  logic signed [41:0] p_val;
  logic signed [63:0] out_sum;
  logic [31:0]        press_val;

  logic        div_start;
  logic [38:0] div_rem_init;
  logic [63:0] div_dividend;
  logic [6:0]  div_steps;
  logic        div_busy;
  logic [63:0] div_quo;
  logic [38:0] div_rem;

  logic fin_op;

  assign t1 = temp_cal[15:0];
  assign t2 = $signed(temp_cal[31:16]);
  assign t3 = $signed(temp_cal[47:32]);
  assign p1 = plow[15:0];
  assign p2 = $signed(plow[31:16]);
  assign p3 = $signed(plow[47:32]);
  assign p4 = $signed(plow[63:48]);
  assign p5 = $signed(pmid[15:0]);
  assign p6 = $signed(pmid[31:16]);
  assign p7 = $signed(pmid[47:32]);
  assign p8 = $signed(pmid[63:48]);
  assign p9 = $signed(ptop);

  assign e1       = $signed({1'b0, adc[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign dlt      = $signed({1'b0, adc[19:4]}) - $signed({1'b0, t1});
  assign v        = 24'(fine) - T_OFFSET_L;
  assign s13      = 29'(preg >>> 13);
  assign span     = 21'h10_0000 - {1'b0, adc};
  assign num_base = $signed({12'b0, span, 31'b0});

  assign fine_sum  = acc + 64'(prod >>> 14);
  assign fine_next = 23'(fine_sum);
  assign t5        = (27'(fine_next) <<< 2) + 27'(fine_next) + 27'sd128;
  assign temp_val  = 24'(t5 >>> 8);

  assign num_mag = acc[63] ? 64'(-acc) : 64'(acc);
  assign den_mag = den[39] ? 39'(-den) : 39'(den);

  // Pressure magnitude is quotient * 3125 plus the fractional quotient,
  // limited to 2^40; a huge first quotient goes straight to the limit.
  assign msum  = 42'(prod) + {30'b0, div_quo[11:0]};
  assign mag   = (qbig || (msum > bsc_pkg::P_LIMIT)) ? bsc_pkg::P_LIMIT : msum;
  assign p_val = qsign ? -$signed(mag) : $signed(mag);

  assign out_sum = (acc2 >>> 8) + (64'(p7) <<< 4);

  always_comb begin
    if (out_sum < 64'sd0) begin
      press_val = '0;
    end else if (out_sum > bsc_pkg::OUT_MAX) begin
      press_val = '1;
    end else begin
      press_val = out_sum[31:0];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    prod_en = 1'b0;
    unique case (cmd.op)
      bsc_pkg::ST_T0: begin
        mul_a = 56'(e1);  mul_b = 17'(t2);  prod_en = 1'b1;
      end
      bsc_pkg::ST_T1: begin
        mul_a = 56'(dlt); mul_b = dlt;  prod_en = 1'b1;
      end
      bsc_pkg::ST_T2: begin
        mul_a = 56'(prod >>> 12); mul_b = 17'(t3); prod_en = 1'b1;
      end
      bsc_pkg::ST_P0: begin
        mul_a = 56'(v); mul_b = 17'(v >>> 12); prod_en = 1'b1;
      end
      bsc_pkg::ST_P1: begin
        mul_a = 56'(v); mul_b = $signed({5'b0, v[11:0]}); prod_en = 1'b1;
      end
      bsc_pkg::ST_P2: begin
        mul_a = 56'(v); mul_b = 17'(p5); prod_en = 1'b1;
      end
      bsc_pkg::ST_P3: begin
        mul_a = 56'(tvv); mul_b = 17'(p6); prod_en = 1'b1;
      end
      bsc_pkg::ST_P4: begin
        mul_a = 56'(v); mul_b = 17'(p2); prod_en = 1'b1;
      end
      bsc_pkg::ST_P5: begin
        mul_a = 56'(tvv); mul_b = 17'(p3); prod_en = 1'b1;
      end
      bsc_pkg::ST_P7: begin
        mul_a = $signed({23'b0, acc2[32:0]}); mul_b = $signed({1'b0, p1});
        prod_en = 1'b1;
      end
      bsc_pkg::ST_P8: begin
        mul_a = 56'(acc2 >>> 33); mul_b = $signed({1'b0, p1}); prod_en = 1'b1;
      end
      bsc_pkg::ST_P11: begin
        mul_a = $signed({17'b0, div_rem}); mul_b = bsc_pkg::SCALE_5P5;
        prod_en = 1'b1;
      end
      bsc_pkg::ST_P12: begin
        mul_a = $signed({27'b0, qlow}); mul_b = bsc_pkg::SCALE_5P5;
        prod_en = 1'b1;
      end
      bsc_pkg::ST_P14: begin
        mul_a = 56'(s13); mul_b = 17'(s13 >>> 12); prod_en = 1'b1;
      end
      bsc_pkg::ST_P15: begin
        mul_a = 56'(s13); mul_b = $signed({5'b0, s13[11:0]}); prod_en = 1'b1;
      end
      bsc_pkg::ST_P16: begin
        mul_a = 56'(preg); mul_b = 17'(p8); prod_en = 1'b1;
      end
      bsc_pkg::ST_P17: begin
        mul_a = $signed(acc[55:0]); mul_b = 17'(p9); prod_en = 1'b1;
      end
      default: begin
        prod_en = 1'b0;
      end
    endcase
  end

  // The second division starts from the remainder already scaled by 3125;
  // its quotient stays below 2^12, so only twelve steps are needed.
  assign div_start = cmd.exec &&
                     (((cmd.op == bsc_pkg::ST_P10) && (den != '0)) ||
                      (cmd.op == bsc_pkg::ST_P12));
  assign div_rem_init = (cmd.op == bsc_pkg::ST_P12) ? prod[50:12] : '0;
  assign div_dividend = (cmd.op == bsc_pkg::ST_P12) ? {prod[11:0], 52'b0} : num_mag;
  assign div_steps    = (cmd.op == bsc_pkg::ST_P12) ? bsc_pkg::DIV_STEPS_FRAC
                                                    : bsc_pkg::DIV_STEPS_FULL;

  bsc_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .rem_init  (div_rem_init),
    .dividend  (div_dividend),
    .divisor   (den_mag),
    .steps     (div_steps),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign fin_op = (cmd.op == bsc_pkg::ST_TFIN) || (cmd.op == bsc_pkg::ST_PFIN) ||
                  (cmd.op == bsc_pkg::ST_ZFIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal  <= '0;
      plow      <= '0;
      pmid      <= '0;
      ptop      <= '0;
      fine      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          bsc_pkg::CFG_TEMP: temp_cal <= cfg_data[47:0];
          bsc_pkg::CFG_PLOW: plow     <= cfg_data;
          bsc_pkg::CFG_PMID: pmid     <= cfg_data;
          bsc_pkg::CFG_PTOP: ptop     <= cfg_data[15:0];
          default: ptop <= ptop;
        endcase
      end
      if (cmd.exec && (cmd.op == bsc_pkg::ST_TFIN)) begin
        fine <= fine_next;
      end
      if (cmd.exec && fin_op) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      adc <= raw_sample;
    end
    if (prod_en && cmd.exec) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.exec) begin
      unique case (cmd.op)
        bsc_pkg::ST_T1:  acc  <= 64'(prod >>> 11);
        bsc_pkg::ST_P1:  acc  <= 64'(prod) <<< 12;
        bsc_pkg::ST_P2:  tvv  <= 46'(acc + 64'(prod));
        bsc_pkg::ST_P3:  acc  <= 64'(prod) <<< 17;
        bsc_pkg::ST_P4:  acc  <= acc + 64'(prod) + (64'(p4) <<< 35);
        bsc_pkg::ST_P5:  acc2 <= 64'(prod) <<< 12;
        bsc_pkg::ST_P6:  acc2 <= acc2 + 64'(prod >>> 8) + bsc_pkg::ACC_BIAS;
        bsc_pkg::ST_P8: begin
          tlo <= prod[48:33];
          acc <= num_base - acc;
        end
        bsc_pkg::ST_P9:  den   <= 40'(prod) + $signed({24'b0, tlo});
        bsc_pkg::ST_P10: qsign <= acc[63] ^ den[39];
        bsc_pkg::ST_P11: begin
          qbig <= (div_quo > bsc_pkg::DIV_LIMIT);
          qlow <= div_quo[28:0];
        end
        bsc_pkg::ST_P13: preg <= p_val;
        bsc_pkg::ST_P15: acc  <= 64'(prod) <<< 12;
        bsc_pkg::ST_P16: acc  <= acc + 64'(prod);
        bsc_pkg::ST_P17: acc2 <= 64'(prod >>> 19);
        bsc_pkg::ST_P18: acc2 <= acc2 + 64'(prod >>> 25) + 64'(preg);
        bsc_pkg::ST_TFIN: begin
          result_kind       <= bsc_pkg::OPC_TEMP;
          temperature_centi <= temp_val;
          pressure_q24_8    <= '0;
          zero_divisor      <= 1'b0;
        end
        bsc_pkg::ST_PFIN: begin
          result_kind       <= bsc_pkg::OPC_PRESS;
          temperature_centi <= '0;
          pressure_q24_8    <= press_val;
          zero_divisor      <= 1'b0;
        end
        bsc_pkg::ST_ZFIN: begin
          result_kind       <= bsc_pkg::OPC_PRESS;
          temperature_centi <= '0;
          pressure_q24_8    <= '0;
          zero_divisor      <= 1'b1;
        end
        default: begin
          qsign <= qsign;
        end
      endcase
    end
  end

  assign stat.den_zero = (den == '0);
  assign stat.div_busy = div_busy;
  assign stat.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

// File: src/bsc_control.sv
`default_nettype none

module bsc_control (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              opcode,
  input  wire bsc_pkg::dp_stat_t stat,
  output logic                   in_stall,
  output bsc_pkg::dp_cmd_t       cmd
);

  logic [4:0] state;
  logic [4:0] state_next;
  logic       exec;

  always_comb begin
    state_next = state;
    exec       = 1'b1;
    unique case (state) inside
      bsc_pkg::ST_IDLE: begin
        exec = 1'b0;
        if (in_valid) begin
          state_next = (opcode == bsc_pkg::OPC_PRESS) ? bsc_pkg::ST_P0 : bsc_pkg::ST_T0;
        end
      end
      bsc_pkg::ST_T0, bsc_pkg::ST_T1, bsc_pkg::ST_T2,
      bsc_pkg::ST_P0, bsc_pkg::ST_P1, bsc_pkg::ST_P2, bsc_pkg::ST_P3,
      bsc_pkg::ST_P4, bsc_pkg::ST_P5, bsc_pkg::ST_P6, bsc_pkg::ST_P7,
      bsc_pkg::ST_P8, bsc_pkg::ST_P9, bsc_pkg::ST_P11, bsc_pkg::ST_P12,
      bsc_pkg::ST_P13, bsc_pkg::ST_P14, bsc_pkg::ST_P15, bsc_pkg::ST_P16,
      bsc_pkg::ST_P17, bsc_pkg::ST_P18: begin
        state_next = state + 5'd1;
      end
      bsc_pkg::ST_P10: begin
        state_next = stat.den_zero ? bsc_pkg::ST_ZFIN : bsc_pkg::ST_DIV1;
      end
      bsc_pkg::ST_DIV1, bsc_pkg::ST_DIV2: begin
        exec = 1'b0;
        if (!stat.div_busy) begin
          state_next = state + 5'd1;
        end
      end
      bsc_pkg::ST_TFIN, bsc_pkg::ST_PFIN, bsc_pkg::ST_ZFIN: begin
        // The result waits here until the output register is free.
        exec = stat.out_free;
        if (stat.out_free) begin
          state_next = bsc_pkg::ST_IDLE;
        end
      end
      default: begin
        exec       = 1'b0;
        state_next = bsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != bsc_pkg::ST_IDLE);
  assign cmd.op   = state;
  assign cmd.exec = exec;
  assign cmd.load = (state == bsc_pkg::ST_IDLE) && in_valid;

endmodule

`default_nettype wire

// File: src/barometric_sensor_compensation.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// cfg       in         cfg_write_en          cfg_index, cfg_data
// in        in         in_valid / in_stall   opcode, raw_sample
// out       out        out_valid / out_stall result_kind, temperature_centi,
//                                            pressure_q24_8, zero_divisor
//
// A temperature transaction passes through T0, T1, T2 and TFIN, which registers the result.
// A pressure transaction is dominated by the 64-step restoring divider followed by
// a 12-step fractional division; a zero divisor ends it before either division.
// One transaction is worked on at a time; the next is accepted in the cycle after
// the result is registered, even while that result waits. A result that finds the
// previous one still stalled holds the controller until it leaves.
// Reset is synchronous and clears the calibration registers and fine temperature.

module barometric_sensor_compensation (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               opcode,
  input  wire logic [19:0]        raw_sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    result_kind,
  output logic signed [23:0]      temperature_centi,
  output logic [31:0]             pressure_q24_8,
  output logic                    zero_divisor
);

  bsc_pkg::dp_cmd_t  cmd;
  bsc_pkg::dp_stat_t stat;

  bsc_control u_control (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  bsc_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .raw_sample        (raw_sample),
    .out_stall         (out_stall),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .result_kind       (result_kind),
    .temperature_centi (temperature_centi),
    .pressure_q24_8    (pressure_q24_8),
    .zero_divisor      (zero_divisor)
  );

endmodule

`default_nettype wire
